### hdl/kl_pkg.sv
// shared types, constants and helpers of the keyword lexer
package kl_pkg;

  localparam int MAX_LEXEME_DEF = 32;

  localparam int KIND_W = 4;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 5;
  localparam int OUT_DATA_W = 24;   // kind, char, position, zero fill

  localparam logic [KIND_W-1:0] KIND_EXIT  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LET   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_IDENT = 4'd2;
  localparam logic [KIND_W-1:0] KIND_INT   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_OPEN  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 4'd5;
  localparam logic [KIND_W-1:0] KIND_SEMI  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_EQ    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ERROR = 4'd8;
  localparam logic [KIND_W-1:0] KIND_END   = 4'd9;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_NUMBER = 2'd2
  } lex_mode_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // input transaction taken
    logic rd_first;   // read the first buffered character
    logic emit_kw;    // load a keyword result
    logic emit_char;  // load a lexeme character result
    logic emit_tail;  // load the trailing single token
    logic finish;     // item done, commit mode and length
  } kl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_results;
    logic go_kw;
    logic go_stream;
    logic tail_valid;
    logic tail_error;
    logic last_char;
    logic out_free;
  } kl_status_t;

  function automatic logic [CHAR_W-1:0] kw_exit_byte(input logic [1:0] i);
    logic [CHAR_W-1:0] b;
    case (i)
      2'd0:    b = 8'h65;  // e
      2'd1:    b = 8'h78;  // x
      2'd2:    b = 8'h69;  // i
      default: b = 8'h74;  // t
    endcase
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] kw_let_byte(input logic [1:0] i);
    logic [CHAR_W-1:0] b;
    case (i)
      2'd0:    b = 8'h6C;  // l
      2'd1:    b = 8'h65;  // e
      2'd2:    b = 8'h74;  // t
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hdl/kl_ram.sv
// generic single-write, single-read ram with registered read data
module kl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/kl_ctrl.sv
// sequencing state machine of the keyword lexer
module kl_ctrl
  import kl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  kl_status_t st,
  output kl_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_ACCEPT = 6'b000001,
    S_KW     = 6'b000010,
    S_READ   = 6'b000100,
    S_EMIT   = 6'b001000,
    S_TAIL   = 6'b010000,
    S_HALT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_ACCEPT: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && st.need_results) begin
          if (st.go_kw) begin
            state_next = S_KW;
          end else if (st.go_stream) begin
            state_next = S_READ;
          end else begin
            state_next = S_TAIL;
          end
        end
      end
      S_KW: begin
        if (st.out_free) begin
          cmd.emit_kw = 1'b1;
          state_next  = S_TAIL;
        end
      end
      S_READ: begin
        cmd.rd_first = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_char = 1'b1;
          if (st.last_char) begin
            state_next = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (!st.tail_valid) begin
          cmd.finish = 1'b1;
          state_next = S_ACCEPT;
        end else if (st.out_free) begin
          cmd.emit_tail = 1'b1;
          cmd.finish    = 1'b1;
          state_next    = st.tail_error ? S_HALT : S_ACCEPT;
        end
      end
      S_HALT: begin
        // items are taken and dropped until reset
        s_tready = 1'b1;
      end
      default: begin
        state_next = S_ACCEPT;
      end
    endcase
  end

endmodule

### hdl/kl_datapath.sv
// lexeme buffer, character classes, keyword match and output register
module kl_datapath
  import kl_pkg::*;
#(
  parameter int MAX_LEXEME = MAX_LEXEME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CHAR_W-1:0]     s_tdata,
  input  logic                  s_tuser,
  input  kl_cmd_t               cmd,
  output kl_status_t            st,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  localparam int LEN_W  = $clog2(MAX_LEXEME + 1);
  localparam int ADDR_W = $clog2(MAX_LEXEME);

  lex_mode_t          mode;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   idx;
  logic               exit_ok;
  logic               let_ok;

  logic [CHAR_W-1:0]  lat_char;
  logic               lat_letter;
  logic               lat_start;
  logic               tail_valid;
  logic [KIND_W-1:0]  tail_kind;

  logic [KIND_W-1:0]  out_kind;
  logic [CHAR_W-1:0]  out_char;
  logic [POS_W-1:0]   out_pos;

  // incoming item classification
  logic               in_eoi, is_letter, is_digit, is_blank;
  logic               extend, full, overflow, flush_now, kw_match, kw_is_exit;
  logic               in_tail_valid;
  logic [KIND_W-1:0]  in_tail_kind;
  logic               absorb;
  logic [LEN_W-1:0]   idx_inc;
  logic               last_char;
  logic               out_free, load;

  // buffer ports
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CHAR_W-1:0]  wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CHAR_W-1:0]  rd_data;

  assign in_eoi    = s_tuser;
  assign is_letter = (s_tdata >= 8'h41 && s_tdata <= 8'h5A) ||
                     (s_tdata >= 8'h61 && s_tdata <= 8'h7A);
  assign is_digit  = s_tdata >= 8'h30 && s_tdata <= 8'h39;
  assign is_blank  = s_tdata == 8'h20 || (s_tdata >= 8'h09 && s_tdata <= 8'h0D);

  assign extend    = !in_eoi && ((mode == MODE_WORD && (is_letter || is_digit)) ||
                                 (mode == MODE_NUMBER && is_digit));
  assign full      = len == LEN_W'(MAX_LEXEME);
  assign overflow  = extend && full;
  assign flush_now = in_eoi || !extend;

  assign kw_is_exit = len == LEN_W'(4) && exit_ok;
  assign kw_match   = mode == MODE_WORD && (kw_is_exit || (len == LEN_W'(3) && let_ok));

  always_comb begin
    in_tail_valid = 1'b1;
    in_tail_kind  = KIND_ERROR;
    if (in_eoi) begin
      in_tail_kind = KIND_END;
    end else if (overflow) begin
      in_tail_kind = KIND_ERROR;
    end else if (extend || is_letter || is_digit || is_blank) begin
      in_tail_valid = 1'b0;
    end else begin
      case (s_tdata)
        8'h28:   in_tail_kind = KIND_OPEN;
        8'h29:   in_tail_kind = KIND_CLOSE;
        8'h3B:   in_tail_kind = KIND_SEMI;
        8'h3D:   in_tail_kind = KIND_EQ;
        default: in_tail_kind = KIND_ERROR;
      endcase
    end
  end

  assign st.need_results = overflow || (flush_now && (mode != MODE_IDLE || in_tail_valid));
  assign st.go_kw        = flush_now && kw_match;
  assign st.go_stream    = flush_now && mode != MODE_IDLE && !kw_match;
  assign st.tail_valid   = tail_valid;
  assign st.tail_error   = tail_kind == KIND_ERROR;
  assign st.last_char    = last_char;
  assign st.out_free     = out_free;

  assign absorb    = cmd.accept && !st.need_results;
  assign idx_inc   = idx + LEN_W'(1);
  assign last_char = idx_inc == len;
  assign out_free  = !m_tvalid || m_tready;
  assign load      = cmd.emit_kw || cmd.emit_char || cmd.emit_tail;

  // buffer write: extend in place, start a fresh lexeme, or start after a flush
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = s_tdata;
    if (absorb && extend) begin
      wr_en   = 1'b1;
      wr_addr = len[ADDR_W-1:0];
    end else if (absorb && (is_letter || is_digit)) begin
      wr_en = 1'b1;
    end else if (cmd.finish && lat_start) begin
      wr_en   = 1'b1;
      wr_data = lat_char;
    end
  end

  assign rd_en   = cmd.rd_first || (cmd.emit_char && !last_char);
  assign rd_addr = cmd.rd_first ? '0 : idx_inc[ADDR_W-1:0];

  kl_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEXEME)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // mode, length and running keyword prefix match
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      len     <= '0;
      exit_ok <= 1'b0;
      let_ok  <= 1'b0;
    end else begin
      if (wr_en) begin
        exit_ok <= (wr_addr == '0 || exit_ok) && {1'b0, wr_addr} < (ADDR_W+1)'(4) &&
                   wr_data == kw_exit_byte(wr_addr[1:0]);
        let_ok  <= (wr_addr == '0 || let_ok) && {1'b0, wr_addr} < (ADDR_W+1)'(3) &&
                   wr_data == kw_let_byte(wr_addr[1:0]);
      end
      if (absorb && extend) begin
        len <= len + LEN_W'(1);
      end else if (absorb && (is_letter || is_digit)) begin
        mode <= is_letter ? MODE_WORD : MODE_NUMBER;
        len  <= LEN_W'(1);
      end else if (cmd.finish) begin
        if (lat_start) begin
          mode <= lat_letter ? MODE_WORD : MODE_NUMBER;
          len  <= LEN_W'(1);
        end else begin
          mode <= MODE_IDLE;
          len  <= '0;
        end
      end
    end
  end

  // item held while its results go out
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lat_char   <= s_tdata;
      lat_letter <= is_letter;
      lat_start  <= !in_eoi && !extend && (is_letter || is_digit);
      tail_valid <= in_tail_valid;
      tail_kind  <= in_tail_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx <= '0;
    end else if (cmd.emit_char) begin
      idx <= idx_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_kw) begin
      out_kind <= kw_is_exit ? KIND_EXIT : KIND_LET;
      out_char <= '0;
      out_pos  <= '0;
      m_tlast  <= 1'b1;
      m_tuser  <= !tail_valid;
    end else if (cmd.emit_char) begin
      out_kind <= (mode == MODE_WORD) ? KIND_IDENT : KIND_INT;
      out_char <= rd_data;
      out_pos  <= POS_W'(idx);
      m_tlast  <= last_char;
      m_tuser  <= last_char && !tail_valid;
    end else if (cmd.emit_tail) begin
      out_kind <= tail_kind;
      out_char <= '0;
      out_pos  <= '0;
      m_tlast  <= 1'b1;
      m_tuser  <= 1'b1;
    end
  end

  assign m_tdata = {(OUT_DATA_W - KIND_W - CHAR_W - POS_W)'(0), out_pos, out_char, out_kind};

endmodule

### hdl/keyword_lexer.sv
// top level of the keyword lexer
//
// input stream: one transaction per source byte in s_tdata; s_tuser high marks
// the end of the source, and s_tdata is then ignored
// output stream: one transaction per token, or per lexeme character for
// identifiers and integer literals; m_tlast closes each token and m_tuser
// marks the last transaction caused by one input transaction
// sequencer steps:
//   a byte that extends a lexeme, or a letter, digit or whitespace in idle mode, is absorbed in the accept state
//   a byte that flushes a pending lexeme of n characters goes through accept,
//   first buffer read, n characters at one per cycle off the single buffer read
//   port while the receiver takes them, then the trailing token if any
//   a keyword flush: accept, keyword, trailing token if any; a single token from idle mode: accept, token
// input is taken only in the accept and halt states of the sequencer
// reset: empty lexeme, idle mode, output empty; the buffer holds no reset value
// receiver stall: the output register holds its transaction and the sequencer
// waits, so nothing is lost; input is refused until the item is finished
// an illegal byte or an overlong lexeme gives an error token, after which every
// input transaction is taken and dropped until reset
module keyword_lexer
  import kl_pkg::*;
#(
  parameter int MAX_LEXEME = MAX_LEXEME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input: [7:0] char_code
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CHAR_W-1:0]     s_tdata,
  // input: [0] end_of_input
  input  logic                  s_tuser,
  // output: [3:0] token_kind, [11:4] lexeme_char, [16:12] char_position, zero above
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  // output: token_end
  output logic                  m_tlast,
  // output: [0] run_last
  output logic                  m_tuser
);

  kl_cmd_t    cmd;
  kl_status_t st;

  // sequencer
  kl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // buffer, classification and output register
  kl_datapath #(
    .MAX_LEXEME (MAX_LEXEME)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

### hdl/kl_checker.sv
// port-level checks of the keyword lexer and their binding
module kl_checker
  import kl_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast,
  input logic                  m_tuser
);

  logic [KIND_W-1:0] kind;
  assign kind = m_tdata[KIND_W-1:0];

  // a stalled transaction stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output transaction dropped while stalled");

  // the last result of an input item always closes a token
  a_run_closes_token: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("run end without token end");

  // single tokens carry no lexeme character or position and always close their token
  a_plain_token: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind != KIND_IDENT && kind != KIND_INT |->
      m_tdata[OUT_DATA_W-1:KIND_W] == '0 && m_tlast)
    else $error("single token with lexeme payload");

  // end and error tokens are always the last result of their item
  a_final_kinds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (kind == KIND_END || kind == KIND_ERROR) |-> m_tuser)
    else $error("end or error token not last of its item");

endmodule

bind keyword_lexer kl_checker u_kl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
